// ===== design/lcg_seed_pattern_search_macros.svh =====
// Assertion macros for the LCG seed pattern search.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef LCG_SEED_PATTERN_SEARCH_MACROS_SVH
`define LCG_SEED_PATTERN_SEARCH_MACROS_SVH
`ifndef SYNTHESIS
`define LSPS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define LSPS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
`else
`define LSPS_ASSERT(label, prop, msg)
`define LSPS_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

// ===== design/lsps_pkg.sv =====
// Shared types and constants for the LCG seed pattern search.
// No dependencies.
package lsps_pkg;

	localparam int WORD_W = 64;
	localparam int HALF_W = 32;
	localparam int CNT_W = 7;
	localparam int CFG_IDX_W = 3;
	localparam int RESULT_CAP_DEF = 64;

	localparam logic [WORD_W-1:0] LCG_MUL = 64'h5d588b656c078965;
	localparam logic [WORD_W-1:0] LCG_ADD = 64'h0000_0000_0026_9ec3;
	localparam logic [6:0] FRAME_SCALE = 7'd100;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BITS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_FILTER = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_END_FILTER = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RESULT_LIMIT = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_JUMP,
		ST_MWAIT,
		ST_FRAME,
		ST_DECIDE,
		ST_REPORT,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		OP_AM,
		OP_AI,
		OP_JI,
		OP_JM,
		OP_APPLY,
		OP_STEP
	} op_t;

endpackage

// ===== design/lcg_seed_pattern_search.sv =====
// Top level of the LCG seed pattern search: config registers, sequencer, result staging.
// Depends on lsps_pkg, lsps_mul64 and lcg_seed_pattern_search_macros.svh.
//
// One seed is searched at a time; in_stall stays high until its last result is staged.
// All 64-bit products go through one shared multiply-add unit; each operation holds the
// sequencer from its issue until the unit signals done. Unfiltered, each frame takes one
// LCG step plus a report per match, and a seed walks max(frame_limit,1) frames, fewer
// once the result limit stops the walk. Filtered, the jump-ahead works through each bit
// of the step count (up to 33 bits), then comes the apply and one LCG step per pattern
// bit. A seed is rejected straight from setup when the result limit is already reached.
// Results are held in one pending register so the final one can be flagged, plus an
// output register.
`include "lcg_seed_pattern_search_macros.svh"
module lcg_seed_pattern_search import lsps_pkg::*; #(
	parameter int RESULT_CAP = RESULT_CAP_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [HALF_W-1:0]    seed,
	input  logic                 new_search,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 matched,
	output logic [HALF_W-1:0]    match_seed,
	output logic [HALF_W-1:0]    window_start,
	output logic [HALF_W-1:0]    window_end,
	output logic                 last,
	output logic                 limit_hit
);

	// config
	logic [HALF_W-1:0] frame_limit_q, start_frm_q, end_frm_q;
	logic [WORD_W-1:0] pattern_bits_q;
	logic [6:0]        pattern_len_q;
	logic [1:0]        filter_mode_q;
	logic [CNT_W-1:0]  match_limit_q;

	// sequencer and datapath
	state_t            state_q, state_d;
	op_t               op_q;
	logic [HALF_W-1:0] seed_q, fc_q, rep_ws_q, rep_we_q;
	logic [CNT_W-1:0]  count_q;
	logic [WORD_W-1:0] lcg_q, win_q, jm_q, ji_q, am_q, ai_q;
	logic [HALF_W:0]   steps_q;
	logic              filt_q;

	// pending and output results
	logic              pend_v_q, pend_lh_q;
	logic [HALF_W-1:0] pend_ws_q, pend_we_q;
	logic              out_v_q, out_m_q, out_last_q, out_lh_q;
	logic [HALF_W-1:0] out_seed_q, out_ws_q, out_we_q;

	// combinational
	logic [CNT_W-1:0]  lim, cnt_inc;
	logic [6:0]        len;
	logic [WORD_W-1:0] mask, win_nx;
	logic [38:0]       bit_prod;
	logic              start_f, no_chk, tgt_ok, out_free, unf_hit, last_frame, out_load;
	logic [HALF_W:0]   target, fc1, len33;
	logic [HALF_W-1:0] sf;
	logic              mul_start, mul_done;
	logic [WORD_W-1:0] mul_a, mul_b, mul_c, mul_res;

	assign lim = (32'(match_limit_q) > RESULT_CAP) ? CNT_W'(RESULT_CAP) : match_limit_q;
	assign len = (pattern_len_q > 7'd64) ? 7'd64 : pattern_len_q;
	assign len33 = {{(HALF_W-6){1'b0}}, len};
	assign mask = len[6] ? {WORD_W{1'b1}} : ((WORD_W'(1) << len[5:0]) - WORD_W'(1));
	assign bit_prod = {7'd0, lcg_q[WORD_W-1:HALF_W]} * {32'd0, FRAME_SCALE};
	assign win_nx = {win_q[WORD_W-2:0], bit_prod[HALF_W]} & mask;
	assign cnt_inc = count_q + CNT_W'(1);
	assign out_free = !out_v_q || !out_stall;
	assign fc1 = {1'b0, fc_q} + 33'd1;
	assign last_frame = fc1 >= {1'b0, frame_limit_q};
	assign unf_hit = (len == 7'd0) || (fc1 >= len33 && win_q == pattern_bits_q);
	assign out_load = (state_q == ST_REPORT && pend_v_q && out_free)
		|| (state_q == ST_FINISH && out_free);

	// filter target window
	assign start_f = filter_mode_q[0] && !filter_mode_q[1];
	assign no_chk = start_f && len == 7'd0 && start_frm_q == '0;
	always_comb begin
		if (start_f)
			target = (len == 7'd0) ? {1'b0, start_frm_q} - 33'd1
				: {1'b0, start_frm_q} + len33 - 33'd1;
		else
			target = {1'b0, end_frm_q};
	end
	assign tgt_ok = !no_chk && !target[HALF_W] && target[HALF_W-1:0] < frame_limit_q
		&& target + 33'd1 >= len33;
	assign sf = target[HALF_W-1:0] - HALF_W'(len) + HALF_W'(1);

	always_comb begin
		mul_start = 1'b0;
		mul_a = lcg_q;
		mul_b = LCG_MUL;
		mul_c = LCG_ADD;
		if (state_q == ST_JUMP) begin
			mul_start = 1'b1;
			unique case (op_q)
				OP_AM: begin
					mul_a = am_q;
					mul_b = jm_q;
					mul_c = '0;
				end
				OP_AI: begin
					mul_a = ai_q;
					mul_b = jm_q;
					mul_c = ji_q;
				end
				OP_JI: begin
					mul_a = ji_q;
					mul_b = jm_q + WORD_W'(1);
					mul_c = '0;
				end
				OP_JM: begin
					mul_a = jm_q;
					mul_b = jm_q;
					mul_c = '0;
				end
				OP_APPLY: begin
					mul_a = am_q;
					mul_b = {{HALF_W{1'b0}}, seed_q};
					mul_c = ai_q;
				end
				default: begin
					mul_a = lcg_q;
					mul_b = LCG_MUL;
					mul_c = LCG_ADD;
				end
			endcase
		end else if (state_q == ST_FRAME) begin
			mul_start = 1'b1;
		end
	end

	lsps_mul64 u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.c      (mul_c),
		.done   (mul_done),
		.result (mul_res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:
				if (in_valid)
					state_d = ST_SETUP;
			ST_SETUP: begin
				if (count_q >= lim)
					state_d = ST_FINISH;
				else if (filter_mode_q == 2'd0)
					state_d = ST_JUMP;
				else if (!tgt_ok)
					state_d = ST_FINISH;
				else if (len == 7'd0)
					state_d = ST_REPORT;
				else
					state_d = ST_JUMP;
			end
			ST_JUMP:
				state_d = ST_MWAIT;
			ST_FRAME:
				state_d = ST_MWAIT;
			ST_MWAIT:
				if (mul_done) begin
					if (op_q == OP_APPLY)
						state_d = ST_FRAME;
					else if (op_q == OP_STEP)
						state_d = ST_DECIDE;
					else
						state_d = ST_JUMP;
				end
			ST_DECIDE: begin
				if (filt_q) begin
					if (fc1 == len33)
						state_d = (win_q == pattern_bits_q) ? ST_REPORT : ST_FINISH;
					else
						state_d = ST_FRAME;
				end else if (unf_hit)
					state_d = ST_REPORT;
				else
					state_d = last_frame ? ST_FINISH : ST_FRAME;
			end
			ST_REPORT:
				if (!pend_v_q || out_free) begin
					if (cnt_inc >= lim || filt_q || last_frame)
						state_d = ST_FINISH;
					else
						state_d = ST_FRAME;
				end
			ST_FINISH:
				if (out_free)
					state_d = ST_IDLE;
			default:
				state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_limit_q <= '0;
			pattern_bits_q <= '0;
			pattern_len_q <= '0;
			filter_mode_q <= '0;
			start_frm_q <= '0;
			end_frm_q <= '0;
			match_limit_q <= CNT_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_LIMIT:  frame_limit_q <= cfg_data[HALF_W-1:0];
				REG_PATTERN_BITS: pattern_bits_q <= cfg_data;
				REG_PATTERN_LEN:  pattern_len_q <= cfg_data[6:0];
				REG_FILTER_MODE:  filter_mode_q <= cfg_data[1:0];
				REG_START_FILTER: start_frm_q <= cfg_data[HALF_W-1:0];
				REG_END_FILTER:   end_frm_q <= cfg_data[HALF_W-1:0];
				REG_RESULT_LIMIT: match_limit_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_v_q <= 1'b0;
			out_v_q <= 1'b0;
			op_q <= OP_STEP;
			filt_q <= 1'b0;
		end else begin
			if (out_load)
				out_v_q <= 1'b1;
			else if (!out_stall)
				out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE:
					if (in_valid && new_search)
						count_q <= '0;
				ST_SETUP: begin
					filt_q <= filter_mode_q != 2'd0;
					if (filter_mode_q == 2'd0)
						op_q <= OP_APPLY;
					else
						op_q <= sf[0] ? OP_JI : OP_AM;  // low bit of sf+1
				end
				ST_FRAME:
					op_q <= OP_STEP;
				ST_MWAIT:
					if (mul_done) begin
						unique case (op_q)
							OP_AM: op_q <= OP_AI;
							OP_AI: op_q <= OP_JI;
							OP_JI: op_q <= OP_JM;
							OP_JM: begin
								if (steps_q[HALF_W:1] == '0)
									op_q <= OP_APPLY;
								else
									op_q <= steps_q[1] ? OP_AM : OP_JI;
							end
							default: ;
						endcase
					end
				ST_REPORT:
					if (!pend_v_q || out_free) begin
						count_q <= cnt_inc;
						pend_v_q <= 1'b1;
					end
				ST_FINISH:
					if (out_free)
						pend_v_q <= 1'b0;
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE:
				if (in_valid)
					seed_q <= seed;
			ST_SETUP: begin
				rep_ws_q <= sf;
				rep_we_q <= target[HALF_W-1:0];
				steps_q <= {1'b0, sf} + 33'd1;
				jm_q <= LCG_MUL;
				ji_q <= LCG_ADD;
				// unfiltered start reuses the apply step as one plain LCG step
				am_q <= (filter_mode_q == 2'd0) ? LCG_MUL : WORD_W'(1);
				ai_q <= (filter_mode_q == 2'd0) ? LCG_ADD : '0;
				win_q <= '0;
				fc_q <= '0;
			end
			ST_FRAME:
				win_q <= win_nx;
			ST_MWAIT:
				if (mul_done) begin
					unique case (op_q)
						OP_AM: am_q <= mul_res;
						OP_AI: ai_q <= mul_res;
						OP_JI: ji_q <= mul_res;
						OP_JM: begin
							jm_q <= mul_res;
							steps_q <= steps_q >> 1;
						end
						OP_APPLY, OP_STEP: lcg_q <= mul_res;
						default: ;
					endcase
				end
			ST_DECIDE: begin
				if (!filt_q) begin
					rep_ws_q <= fc_q - HALF_W'(len) + HALF_W'(1);
					rep_we_q <= fc_q;
				end
				if (filt_q ? (fc1 != len33) : (!unf_hit && !last_frame))
					fc_q <= fc1[HALF_W-1:0];
			end
			ST_REPORT:
				if (!pend_v_q || out_free) begin
					pend_ws_q <= rep_ws_q;
					pend_we_q <= rep_we_q;
					pend_lh_q <= cnt_inc >= lim;
					if (pend_v_q) begin
						out_m_q <= 1'b1;
						out_seed_q <= seed_q;
						out_ws_q <= pend_ws_q;
						out_we_q <= pend_we_q;
						out_last_q <= 1'b0;
						out_lh_q <= pend_lh_q;
					end
					if (!filt_q && cnt_inc < lim && !last_frame)
						fc_q <= fc1[HALF_W-1:0];
				end
			ST_FINISH:
				if (out_free) begin
					out_m_q <= pend_v_q;
					out_seed_q <= seed_q;
					out_ws_q <= pend_v_q ? pend_ws_q : '0;
					out_we_q <= pend_v_q ? pend_we_q : '0;
					out_last_q <= 1'b1;
					out_lh_q <= pend_v_q ? pend_lh_q : (count_q >= lim);
				end
			default: ;
		endcase
	end

	assign in_stall = state_q != ST_IDLE;
	assign out_valid = out_v_q;
	assign matched = out_m_q;
	assign match_seed = out_seed_q;
	assign window_start = out_ws_q;
	assign window_end = out_we_q;
	assign last = out_last_q;
	assign limit_hit = out_lh_q;

	`LSPS_ASSERT_IMP(a_done_in_wait, mul_done, state_q == ST_MWAIT, "mul result outside wait")
	`LSPS_ASSERT_IMP(a_idle_no_pend, state_q == ST_IDLE, !pend_v_q, "pending result left")
	`LSPS_ASSERT_IMP(a_out_src, $rose(out_v_q),
		$past(state_q == ST_REPORT) || $past(state_q == ST_FINISH), "stray result")
	`LSPS_ASSERT_IMP(a_count_step, $past(state_q == ST_REPORT) && count_q != $past(count_q),
		count_q == $past(count_q) + CNT_W'(1), "match count jumped")

endmodule

// ===== design/lsps_mul64.sv =====
// Shared 64x64 (low half) multiply-add: result = a*b + c, with done raised as the last partial product is added.
// One 32x32 multiplier, three partial products accumulated one per cycle; depends on lsps_pkg.
module lsps_mul64 import lsps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] a,
	input  logic [WORD_W-1:0] b,
	input  logic [WORD_W-1:0] c,
	output logic              done,
	output logic [WORD_W-1:0] result
);

	logic [1:0]        phase_q;
	logic              done_q;
	logic [WORD_W-1:0] a_q, b_q, acc_q;
	logic [HALF_W-1:0] x, y;
	logic [WORD_W-1:0] pp, addend;

	always_comb begin
		unique case (phase_q)
			2'd1: begin
				x = a_q[HALF_W-1:0];
				y = b_q[HALF_W-1:0];
			end
			2'd2: begin
				x = a_q[HALF_W-1:0];
				y = b_q[WORD_W-1:HALF_W];
			end
			default: begin
				x = a_q[WORD_W-1:HALF_W];
				y = b_q[HALF_W-1:0];
			end
		endcase
		pp = WORD_W'(x) * WORD_W'(y);
		// cross terms only reach the upper half
		addend = (phase_q == 2'd1) ? pp : {pp[HALF_W-1:0], {HALF_W{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= (phase_q == 2'd3);
			if (start)
				phase_q <= 2'd1;
			else if (phase_q != 2'd0)
				phase_q <= (phase_q == 2'd3) ? 2'd0 : phase_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			acc_q <= c;
		end else if (phase_q != 2'd0) begin
			acc_q <= acc_q + addend;
		end
	end

	assign done = done_q;
	assign result = acc_q;

endmodule

// ===== test/lsps_checker.sv =====
// Result checker for the LCG seed pattern search: follows the config writes and accepted
// requests, works out the expected results and compares each delivered one in order.
// Depends on lsps_pkg.
module lsps_checker import lsps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [HALF_W-1:0]    seed,
	input  logic                 new_search,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 matched,
	input  logic [HALF_W-1:0]    match_seed,
	input  logic [HALF_W-1:0]    window_start,
	input  logic [HALF_W-1:0]    window_end,
	input  logic                 last,
	input  logic                 limit_hit,
	output int                   errors,
	output int                   outstanding,
	output int                   results_seen
);

	typedef struct packed {
		logic        matched;
		logic [31:0] seed;
		logic [31:0] wstart;
		logic [31:0] wend;
		logic        last;
		logic        lhit;
	} search_result_t;

	search_result_t pending_q[$];

	logic [31:0] frame_limit;
	logic [63:0] pattern_bits;
	logic [6:0]  pattern_len;
	logic [1:0]  filter_mode;
	logic [31:0] start_frm;
	logic [31:0] end_frm;
	logic [6:0]  match_limit;
	logic [6:0]  match_count;

	assign outstanding = pending_q.size();

	function automatic logic [63:0] lcg_advance(input logic [63:0] s);
		return s * LCG_MUL + LCG_ADD;
	endfunction

	// binary jump-ahead: compose the affine map s -> s*M + C over 'steps' applications
	function automatic logic [63:0] lcg_skip(input logic [63:0] s, input logic [63:0] steps);
		logic [63:0] jm, ji, am, ai, n;
		jm = LCG_MUL;
		ji = LCG_ADD;
		am = 64'd1;
		ai = 64'd0;
		n = steps;
		while (n != 0) begin
			if (n[0]) begin
				am = am * jm;
				ai = ai * jm + ji;
			end
			ji = ji * (jm + 64'd1);
			jm = jm * jm;
			n = n >> 1;
		end
		return am * s + ai;
	endfunction

	function automatic logic frame_bit(input logic [63:0] s);
		logic [63:0] p;
		p = {32'd0, s[63:32]} * 64'd100;
		return p[32];
	endfunction

	function automatic bit log_match(input logic [31:0] sd, input logic [31:0] ws,
			input logic [31:0] we, input logic [6:0] lim);
		if (match_count >= lim)
			return 0;
		match_count = match_count + 7'd1;
		pending_q.push_back('{1'b1, sd, ws, we, 1'b0, match_count >= lim});
		return match_count < lim;
	endfunction

	task automatic predict_seed(input logic [31:0] sd, input logic ns);
		logic [6:0]  lim;
		logic [31:0] len, tf, sf, fc;
		logic [63:0] mask, target, st, win;
		logic        end_f, start_f, ok;
		int          prior_cnt;
		lim = match_limit > 7'd64 ? 7'd64 : match_limit;
		len = pattern_len > 7'd64 ? 32'd64 : {25'd0, pattern_len};
		mask = len == 0 ? 64'd0 : (len == 64 ? '1 : ((64'd1 << len) - 64'd1));
		end_f = filter_mode[1];
		start_f = filter_mode[0] && !end_f;
		prior_cnt = pending_q.size();
		if (ns)
			match_count = 0;
		if (match_count < lim) begin
			if (start_f || end_f) begin
				target = {32'd0, end_frm};
				if (start_f) begin
					if (len == 0)
						target = start_frm == 0 ? '1 : {32'd0, start_frm} - 64'd1;
					else
						target = {32'd0, start_frm} + {32'd0, len} - 64'd1;
				end
				if (target <= 64'hFFFF_FFFF && target < {32'd0, frame_limit} &&
						target + 64'd1 >= {32'd0, len}) begin
					tf = target[31:0];
					sf = tf - len + 32'd1;
					ok = 1'b1;
					if (len != 0) begin
						st = lcg_skip({32'd0, sd}, {32'd0, sf} + 64'd1);
						win = 0;
						for (int i = 0; i < len; i++) begin
							win = ((win << 1) | frame_bit(st)) & mask;
							st = lcg_advance(st);
						end
						ok = win == pattern_bits;
					end
					if (ok)
						void'(log_match(sd, sf, tf, lim));
				end
			end else begin
				st = lcg_advance({32'd0, sd});
				win = 0;
				fc = 0;
				forever begin
					win = ((win << 1) | frame_bit(st)) & mask;
					st = lcg_advance(st);
					if (len == 0 || ({32'd0, fc} + 64'd1 >= {32'd0, len} && win == pattern_bits))
						if (!log_match(sd, fc - len + 32'd1, fc, lim))
							break;
					if ({32'd0, fc} + 64'd1 >= {32'd0, frame_limit})
						break;
					fc++;
				end
			end
		end
		if (pending_q.size() == prior_cnt)
			pending_q.push_back('{1'b0, sd, 32'd0, 32'd0, 1'b0, match_count >= lim});
		pending_q[$].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		search_result_t got, want;
		if (!arst_n) begin
			frame_limit = 0;
			pattern_bits = 0;
			pattern_len = 0;
			filter_mode = 0;
			start_frm = 0;
			end_frm = 0;
			match_limit = 7'd64;
			match_count = 0;
			errors = 0;
			results_seen = 0;
			pending_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				got = '{matched, match_seed, window_start, window_end, last, limit_hit};
				results_seen++;
				if (pending_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: %p", got);
				end else begin
					want = pending_q.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("result mismatch: expected %p, got %p", want, got);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_LIMIT:  frame_limit = cfg_data[31:0];
					REG_PATTERN_BITS: pattern_bits = cfg_data;
					REG_PATTERN_LEN:  pattern_len = cfg_data[6:0];
					REG_FILTER_MODE:  filter_mode = cfg_data[1:0];
					REG_START_FILTER: start_frm = cfg_data[31:0];
					REG_END_FILTER:   end_frm = cfg_data[31:0];
					REG_RESULT_LIMIT: match_limit = cfg_data[6:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_seed(seed, new_search);
		end
	end

endmodule

// ===== test/testbench.sv =====
// Top of the LCG seed pattern search bench: clock, reset, config phases and seed requests.
// Depends on lsps_pkg, lcg_seed_pattern_search and lsps_checker.
module testbench;
	import lsps_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_LIMIT;
	logic [WORD_W-1:0]    cfg_data = 0;
	logic                 in_valid = 0;
	logic                 in_stall;
	logic [HALF_W-1:0]    seed = 0;
	logic                 new_search = 0;
	logic                 out_valid;
	logic                 out_stall = 0;
	logic                 matched, last, limit_hit;
	logic [HALF_W-1:0]    match_seed, window_start, window_end;

	int errors, outstanding, results_seen;
	int cycles = 0;
	int seeds_sent = 0;
	int phases = 0;
	bit quiet = 0;
	bit hold_go = 0;
	bit hold_used = 0;
	int hold_cnt = 0;
	int burst = 0;
	logic in_acc;

	always #5 clk = ~clk;

	lcg_seed_pattern_search u_dut (.*);

	lsps_checker u_chk (.*);

	always @(posedge clk or negedge arst_n)
		if (!arst_n)
			in_acc <= 1'b0;
		else
			in_acc <= in_valid && !in_stall;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// result-side backpressure: random bursts, one long hold-off when asked
	always @(negedge clk) begin
		if (hold_go && !hold_used) begin
			hold_used = 1;
			hold_cnt = 400;
		end
		if (hold_cnt > 0) begin
			out_stall = 1;
			hold_cnt--;
		end else if (quiet) begin
			out_stall = 0;
		end else if (burst > 0) begin
			out_stall = 1;
			burst--;
		end else if ($urandom_range(4) == 0) begin
			out_stall = 1;
			burst = $urandom_range(0, 4);
		end else begin
			out_stall = 0;
		end
	end

	task automatic send_seed(input logic [31:0] sd, input logic ns);
		if (!quiet && $urandom_range(3) == 0) begin
			in_valid = 0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_valid = 1;
		seed = sd;
		new_search = ns;
		do @(negedge clk); while (!in_acc);
		seeds_sent++;
	endtask

	// wait out every result, then a short settle before touching registers
	task automatic drain;
		in_valid = 0;
		while (outstanding != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic program_regs(input logic [31:0] fl, input logic [63:0] pb,
			input logic [6:0] pl, input logic [1:0] fm, input logic [31:0] sff,
			input logic [31:0] eff, input logic [6:0] rl);
		logic [CFG_IDX_W-1:0] idx[7];
		logic [63:0] val[7];
		idx = '{REG_FRAME_LIMIT, REG_PATTERN_BITS, REG_PATTERN_LEN, REG_FILTER_MODE,
			REG_START_FILTER, REG_END_FILTER, REG_RESULT_LIMIT};
		val = '{{32'd0, fl}, pb, {57'd0, pl}, {62'd0, fm}, {32'd0, sff}, {32'd0, eff},
			{57'd0, rl}};
		for (int i = 0; i < 7; i++) begin
			cfg_we = 1;
			cfg_index = idx[i];
			cfg_data = val[i];
			@(negedge clk);
		end
		cfg_we = 0;
		@(negedge clk);
		phases++;
	endtask

	initial begin
		logic [31:0] fl, sff, eff;
		logic [63:0] pb, mask;
		logic [6:0]  pl, rl;
		logic [1:0]  fm;
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// defaults: one frame, empty pattern, so every seed matches once
		send_seed(32'h0000_0000, 1);
		send_seed(32'hFFFF_FFFF, 0);
		send_seed(32'h1234_5678, 0);
		drain();
		program_regs(20, 64'h5, 3, 0, 0, 0, 5);
		send_seed(32'hDEAD_BEEF, 1);
		send_seed(32'h0000_0001, 0);
		send_seed(32'h8000_0000, 0);
		drain();
		// huge walk stopped by the limit, then a seed refused because the limit is reached
		program_regs(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 3);
		send_seed(32'hA5A5_5A5A, 1);
		send_seed(32'h5A5A_A5A5, 0);
		drain();
		program_regs(70, {$urandom, $urandom}, 100, 0, 0, 0, 100);
		send_seed($urandom, 1);
		drain();
		program_regs(30, 64'hF0, 3, 0, 0, 0, 127);
		send_seed($urandom, 1);
		drain();
		program_regs(10, 0, 0, 0, 0, 0, 0);
		send_seed($urandom, 1);
		drain();
		// start filter with empty pattern: start zero means nothing is checked
		program_regs(100, 0, 0, 1, 0, 0, 10);
		send_seed($urandom, 1);
		drain();
		program_regs(100, 0, 0, 1, 5, 0, 10);
		send_seed($urandom, 1);
		drain();
		program_regs(32'hFFFF_FFFF, {$urandom, $urandom}, 8, 1, 32'hFFFF_FFFF, 0, 64);
		send_seed($urandom, 1);
		drain();
		program_regs(32'hFFFF_FFFF, {56'd0, 8'($urandom)}, 8, 2, 0, 32'hFFFF_FFFE, 64);
		send_seed($urandom, 1);
		send_seed($urandom, 0);
		drain();
		program_regs(100, 64'h3, 8, 3, 7, 3, 64);
		send_seed($urandom, 1);
		drain();
		program_regs(20, 64'h1, 1, 2, 0, 50, 64);
		send_seed($urandom, 1);
		drain();

		for (int ph = 0; ph < 14; ph++) begin
			fm = 2'($urandom_range(3));
			rl = $urandom_range(9) == 0 ? 7'($urandom_range(0, 127)) : 7'($urandom_range(1, 12));
			pl = $urandom_range(9) == 0 ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 5));
			mask = pl >= 64 ? '1 : ((64'd1 << pl) - 64'd1);
			pb = {$urandom, $urandom};
			if ($urandom_range(4) != 0)
				pb = pb & mask;
			sff = $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 200);
			eff = $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 200);
			if (fm != 0)
				fl = $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 200);
			else if (pl == 0 && $urandom_range(3) == 0)
				fl = $urandom;
			else
				fl = $urandom_range(0, 60);
			if (ph == 13)
				quiet = 1;
			program_regs(fl, pb, pl, fm, sff, eff, rl);
			if (ph == 5)
				hold_go = 1;
			for (int k = 0; k < 25; k++)
				send_seed($urandom, k == 0 || $urandom_range(3) == 0);
			drain();
		end

		$display("Searched %0d seeds over %0d register settings, %0d results checked.",
			seeds_sent, phases, results_seen);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/lsps_pkg.sv
design/lsps_mul64.sv
design/lcg_seed_pattern_search.sv
test/lsps_checker.sv
test/testbench.sv
